>>> sv/tpse_pkg.sv
// package: types, constants and codes for the sorted expiry timer pool
`timescale 1ns / 1ps
package tpse_pkg;
  localparam int unsigned TIMERS    = 32;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned ID_W      = $clog2(TIMERS);
  localparam int unsigned CNT_W     = $clog2(TIMERS + 1);
  localparam int unsigned MAX_RES   = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_RESTART = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_STATE = 2'd2,
    ST_BAD_ID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TS_FREE  = 2'd0,
    TS_ALLOC = 2'd1,
    TS_RUN   = 2'd2
  } tstate_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_TICK_CHK,
    S_TICK_POP,
    S_TICK_NONE,
    S_ADD_POP,
    S_ARM_START,
    S_ARM_WALK,
    S_ARM_LINK,
    S_UNL_WALK,
    S_UNL_LINK,
    S_DEL_FREE,
    S_EMIT
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic latch_in;
    logic tick_adv;
    logic tick_pop;
    logic add_pop;
    logic arm_start;
    logic arm_step;
    logic arm_link;
    logic unl_start;
    logic unl_step;
    logic unl_link;
    logic del_free;
    logic emit;
    logic emit_last;
    logic emit_exp;
    logic [1:0] emit_status;
    logic emit_id_sel;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    op_t  op;
    logic id_bad;
    tstate_t id_state;
    logic free_empty;
    logic head_due;
    logic head_valid;
    logic arm_stop;
    logic unl_found;
    logic unl_stop;
    logic pop_limit;
    logic pop_any;
  } stat_t;
endpackage

>>> sv/timer_pool_sorted_expiry_unit.sv
// top level of the sorted expiry timer pool
`timescale 1ns / 1ps
// One word per start; busy is high while it is worked on, and the walks along
// the sorted list go one link a cycle. A tick advances the time and pops each
// due timer with one result word per expired timer, or gives one word when
// nothing is due. An add takes a free timer and walks the list to insert it;
// a restart of an allocated timer inserts it; a restart of a running timer
// unlinks and re-inserts it; a delete frees the timer, after the unlink walk
// for a running timer; a bad id or a free timer is answered without a walk.
// Results appear for one cycle with out_valid; the receiver cannot stall.
// After reset or a pool_size write a clearing pass refills the free queue.
module timer_pool_sorted_expiry_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_timer_id,
  input  logic [31:0] in_interval,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_result_id,
  output logic        out_expired,
  output logic        out_last_result,
  output logic [31:0] out_now_time,
  output logic [5:0]  out_used_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  tpse_pkg::ctrl_t ctrl;
  tpse_pkg::stat_t stat;
  logic            cfg_wr;
  logic [5:0]      pool_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {26'd0, pool_q} : 32'd0;

  tpse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cfg_wr(cfg_wr),
    .busy(busy), .stat(stat), .ctrl(ctrl)
  );

  tpse_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .in_operation(in_operation), .in_timer_id(in_timer_id),
    .in_interval(in_interval), .cfg_wr(cfg_wr), .cfg_wdata(pwdata[5:0]),
    .pool_size_q(pool_q), .out_valid(out_valid), .out_status(out_status),
    .out_result_id(out_result_id), .out_expired(out_expired),
    .out_last_result(out_last_result), .out_now_time(out_now_time),
    .out_used_count(out_used_count)
  );
endmodule

>>> sv/tpse_datapath.sv
// datapath: timer tables, sorted list links, free queue and walk pointers
`timescale 1ns / 1ps
module tpse_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tpse_pkg::ctrl_t                        ctrl,
  output tpse_pkg::stat_t                        stat,
  input  logic [1:0]                             in_operation,
  input  logic [4:0]                             in_timer_id,
  input  logic [31:0]                            in_interval,
  input  logic                                   cfg_wr,
  input  logic [5:0]                             cfg_wdata,
  output logic [5:0]                             pool_size_q,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [4:0]                             out_result_id,
  output logic                                   out_expired,
  output logic                                   out_last_result,
  output logic [31:0]                            out_now_time,
  output logic [5:0]                             out_used_count
);
  localparam int unsigned IW = tpse_pkg::ID_W;
  localparam int unsigned CW = tpse_pkg::CNT_W;
  localparam int unsigned TB = tpse_pkg::TIME_BITS;
  localparam int unsigned N  = tpse_pkg::TIMERS;

  logic [1:0]    state_r [N];
  logic [1:0]    state_nxt [N];
  logic [TB-1:0] exp_mem [N];
  logic [TB-1:0] ivl_mem [N];
  logic [IW-1:0] link_mem [N];
  logic [IW-1:0] fq_mem [N];
  // link valid flags (end of list marker per entry)
  logic          lnk_v_r [N];
  logic          pop_hv;

  logic [CW-1:0] pool_r;
  logic [IW-1:0] fhead_r;
  logic [CW-1:0] fcnt_r;
  logic [TB-1:0] now_r;
  logic [5:0]    used_r;
  logic          head_v_r;
  logic [IW-1:0] head_r;
  logic [IW-1:0] clr_r;
  logic [IW:0]   clr_cnt_r;

  logic [1:0]    op_r;
  logic [IW-1:0] id_r;
  logic [TB-1:0] ival_r;
  logic [IW-1:0] tid_r;
  logic [TB-1:0] key_r;
  logic          prev_v_r;
  logic [IW-1:0] prev_r;
  logic          cur_v_r;
  logic [IW-1:0] cur_r;
  logic [CW-1:0] guard_r;
  logic [CW-1:0] pops_r;
  logic [IW-1:0] emit_id_r;

  logic [5:0]    cfg_v;
  logic [CW-1:0] pool_w;
  logic [IW-1:0] fhead_inc;
  logic [CW:0]   tail_sum;
  logic [IW-1:0] tail_idx;

  always_comb begin
    cfg_v = cfg_wdata;
    if (cfg_v == 6'd0) cfg_v = 6'd1;
    if (cfg_v > 6'(N)) cfg_v = 6'(N);
    pool_w = CW'(cfg_v);
  end

  assign fhead_inc = (CW'(fhead_r) + CW'(1) >= pool_r) ? '0 : IW'(fhead_r + IW'(1));
  always_comb begin
    tail_sum = (CW+1)'(fhead_r) + (CW+1)'(fcnt_r);
    if (tail_sum >= (CW+1)'(pool_r)) tail_sum = tail_sum - (CW+1)'(pool_r);
    tail_idx = IW'(tail_sum);
  end

  // tick pop moves head along list
  assign pop_hv = lnk_v_r[head_r];

  // status to controller
  always_comb begin
    stat.clear_done = (clr_cnt_r == '0);
    stat.op         = tpse_pkg::op_t'(op_r);
    stat.id_bad     = (CW'(id_r) >= pool_r);
    stat.id_state   = tpse_pkg::tstate_t'(state_r[id_r]);
    stat.free_empty = (fcnt_r == '0);
    stat.head_valid = head_v_r;
    stat.head_due   = head_v_r && (exp_mem[head_r] <= now_r);
    stat.arm_stop   = !cur_v_r || (exp_mem[cur_r] > key_r) || (guard_r >= CW'(N));
    stat.unl_found  = cur_v_r && (cur_r == tid_r);
    stat.unl_stop   = !cur_v_r || (cur_r == tid_r) || (guard_r >= CW'(N));
    stat.pop_limit  = (pops_r >= CW'(tpse_pkg::MAX_RES));
    stat.pop_any    = (pops_r != '0);
  end

  // per timer state flags
  always_comb begin
    for (int i = 0; i < N; i++) begin
      state_nxt[i] = state_r[i];
      if (ctrl.clear_start) state_nxt[i] = tpse_pkg::TS_FREE;
    end
    if (ctrl.tick_pop) state_nxt[head_r] = tpse_pkg::TS_ALLOC;
    if (ctrl.arm_link) state_nxt[tid_r] = tpse_pkg::TS_RUN;
    if (ctrl.unl_link) state_nxt[tid_r] = tpse_pkg::TS_ALLOC;
    if (ctrl.del_free) state_nxt[tid_r] = tpse_pkg::TS_FREE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) state_r[i] <= tpse_pkg::TS_FREE;
    end else begin
      for (int i = 0; i < N; i++) state_r[i] <= state_nxt[i];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (ctrl.clear_step) fq_mem[clr_r] <= clr_r;
    else if (ctrl.del_free && fcnt_r < pool_r) fq_mem[tail_idx] <= tid_r;
    if (ctrl.add_pop) ivl_mem[fq_mem[fhead_r]] <= ival_r;
    if (ctrl.arm_link) begin
      exp_mem[tid_r]  <= key_r;
      link_mem[tid_r] <= cur_r;
      if (prev_v_r) link_mem[prev_r] <= tid_r;
    end
    if (ctrl.unl_link && prev_v_r) link_mem[prev_r] <= link_mem[tid_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r    <= CW'(N);
      fhead_r   <= '0;
      fcnt_r    <= CW'(N);
      now_r     <= '0;
      used_r    <= '0;
      head_v_r  <= 1'b0;
      head_r    <= '0;
      clr_r     <= '0;
      clr_cnt_r <= (IW+1)'(N);
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_wr) begin
        pool_r <= pool_w;
        fcnt_r <= pool_w;
      end
      if (ctrl.clear_start) begin
        fhead_r   <= '0;
        now_r     <= '0;
        used_r    <= '0;
        head_v_r  <= 1'b0;
        clr_r     <= '0;
        clr_cnt_r <= (IW+1)'(N);
      end
      if (ctrl.clear_step) begin
        clr_r     <= clr_r + IW'(1);
        clr_cnt_r <= clr_cnt_r - (IW+1)'(1);
      end
      if (ctrl.tick_adv) now_r <= now_r + TB'(1);
      if (ctrl.tick_pop) begin
        head_r   <= link_mem[head_r];
        head_v_r <= pop_hv;
      end
      if (ctrl.add_pop) begin
        fhead_r <= fhead_inc;
        fcnt_r  <= fcnt_r - CW'(1);
        if (used_r != 6'd63) used_r <= used_r + 6'd1;
      end
      if (ctrl.arm_link && !prev_v_r) begin
        head_r   <= tid_r;
        head_v_r <= 1'b1;
      end
      if (ctrl.unl_link && !prev_v_r) begin
        head_r   <= link_mem[tid_r];
        head_v_r <= lnk_v_r[tid_r];
      end
      if (ctrl.del_free) begin
        if (fcnt_r < pool_r) fcnt_r <= fcnt_r + CW'(1);
        if (used_r != 6'd0) used_r <= used_r - 6'd1;
      end
      if (ctrl.emit) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) lnk_v_r[i] <= 1'b0;
    end else begin
      if (ctrl.arm_link) begin
        lnk_v_r[tid_r] <= cur_v_r;
        if (prev_v_r) lnk_v_r[prev_r] <= 1'b1;
      end
      if (ctrl.unl_link && prev_v_r) lnk_v_r[prev_r] <= lnk_v_r[tid_r];
    end
  end

  // walk and word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pops_r <= '0;
    end else begin
      if (ctrl.latch_in) pops_r <= '0;
      if (ctrl.tick_pop) pops_r <= pops_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      op_r   <= in_operation;
      id_r   <= IW'(in_timer_id);
      ival_r <= TB'(in_interval);
      tid_r  <= IW'(in_timer_id);
    end
    if (ctrl.add_pop) tid_r <= fq_mem[fhead_r];
    if (ctrl.tick_pop) emit_id_r <= head_r;
    if (ctrl.add_pop) emit_id_r <= fq_mem[fhead_r];
    if (ctrl.arm_start) begin
      key_r    <= now_r + ivl_mem[tid_r];
      prev_v_r <= 1'b0;
      cur_v_r  <= head_v_r;
      cur_r    <= head_r;
      guard_r  <= '0;
    end
    if (ctrl.unl_start) begin
      prev_v_r <= 1'b0;
      cur_v_r  <= head_v_r;
      cur_r    <= head_r;
      guard_r  <= '0;
    end
    if (ctrl.arm_step || ctrl.unl_step) begin
      prev_v_r <= 1'b1;
      prev_r   <= cur_r;
      cur_v_r  <= lnk_v_r[cur_r];
      cur_r    <= link_mem[cur_r];
      guard_r  <= guard_r + CW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_status      <= ctrl.emit_status;
      out_result_id   <= ctrl.emit_id_sel ? 5'(emit_id_r) : 5'd0;
      out_expired     <= ctrl.emit_exp;
      out_last_result <= ctrl.emit_last;
      out_now_time    <= 32'(now_r);
      out_used_count  <= used_r;
    end
  end

  assign pool_size_q = 6'(pool_r);
endmodule

>>> sv/tpse_ctrl.sv
// controller: sequences tick, add, restart and delete over the datapath
`timescale 1ns / 1ps
module tpse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            cfg_wr,
  output logic            busy,
  input  tpse_pkg::stat_t stat,
  output tpse_pkg::ctrl_t ctrl
);
  tpse_pkg::fsm_t state_r, state_nxt;
  logic restart_r, restart_nxt;
  logic busy_add_r, bad_state_r;
  logic unl_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tpse_pkg::S_CLEAR;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    restart_nxt = restart_r;
    unique case (state_r)
      tpse_pkg::S_IDLE: begin
        if (cfg_wr) state_nxt = tpse_pkg::S_CLEAR;
        else if (start) state_nxt = tpse_pkg::S_DECODE;
      end
      tpse_pkg::S_CLEAR: if (stat.clear_done) state_nxt = tpse_pkg::S_IDLE;
      tpse_pkg::S_DECODE: begin
        unique case (stat.op)
          tpse_pkg::OP_TICK: state_nxt = tpse_pkg::S_TICK_CHK;
          tpse_pkg::OP_ADD:
            state_nxt = stat.free_empty ? tpse_pkg::S_EMIT : tpse_pkg::S_ADD_POP;
          default: begin
            restart_nxt = (stat.op == tpse_pkg::OP_RESTART);
            if (stat.id_bad || stat.id_state == tpse_pkg::TS_FREE)
              state_nxt = tpse_pkg::S_EMIT;
            else if (stat.id_state == tpse_pkg::TS_RUN)
              state_nxt = tpse_pkg::S_UNL_WALK;
            else if (stat.op == tpse_pkg::OP_RESTART)
              state_nxt = tpse_pkg::S_ARM_START;
            else
              state_nxt = tpse_pkg::S_DEL_FREE;
          end
        endcase
      end
      tpse_pkg::S_TICK_CHK: begin
        if (stat.head_due && !stat.pop_limit) state_nxt = tpse_pkg::S_TICK_POP;
        else if (stat.pop_any) state_nxt = tpse_pkg::S_IDLE;
        else state_nxt = tpse_pkg::S_TICK_NONE;
      end
      tpse_pkg::S_TICK_POP: state_nxt = tpse_pkg::S_TICK_CHK;
      tpse_pkg::S_TICK_NONE: state_nxt = tpse_pkg::S_IDLE;
      tpse_pkg::S_ADD_POP: state_nxt = tpse_pkg::S_ARM_START;
      tpse_pkg::S_ARM_START: state_nxt = tpse_pkg::S_ARM_WALK;
      tpse_pkg::S_ARM_WALK: if (stat.arm_stop) state_nxt = tpse_pkg::S_ARM_LINK;
      tpse_pkg::S_ARM_LINK: state_nxt = tpse_pkg::S_EMIT;
      tpse_pkg::S_UNL_WALK: if (stat.unl_stop) state_nxt = tpse_pkg::S_UNL_LINK;
      tpse_pkg::S_UNL_LINK: begin
        if (!stat.unl_found) state_nxt = tpse_pkg::S_EMIT;
        else if (restart_r) state_nxt = tpse_pkg::S_ARM_START;
        else state_nxt = tpse_pkg::S_DEL_FREE;
      end
      tpse_pkg::S_DEL_FREE: state_nxt = tpse_pkg::S_EMIT;
      tpse_pkg::S_EMIT: state_nxt = tpse_pkg::S_IDLE;
      default: state_nxt = tpse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) unl_seen_r <= 1'b0;
    else if (state_r == tpse_pkg::S_DECODE) unl_seen_r <= 1'b0;
    else if (state_r == tpse_pkg::S_UNL_LINK) unl_seen_r <= !stat.unl_found;
  end

  always_comb begin
    ctrl = '0;
    busy = (state_r != tpse_pkg::S_IDLE);
    unique case (state_r)
      tpse_pkg::S_IDLE: begin
        ctrl.clear_start = cfg_wr;
        ctrl.latch_in    = start && !cfg_wr;
      end
      tpse_pkg::S_CLEAR: ctrl.clear_step = !stat.clear_done;
      tpse_pkg::S_DECODE: ctrl.tick_adv = (stat.op == tpse_pkg::OP_TICK);
      // word of the timer popped last, last when no further pop follows
      tpse_pkg::S_TICK_CHK: begin
        ctrl.emit        = stat.pop_any;
        ctrl.emit_exp    = 1'b1;
        ctrl.emit_id_sel = 1'b1;
        ctrl.emit_last   = !(stat.head_due && !stat.pop_limit);
        ctrl.emit_status = tpse_pkg::ST_OK;
      end
      tpse_pkg::S_TICK_POP: ctrl.tick_pop = 1'b1;
      tpse_pkg::S_TICK_NONE: begin
        ctrl.emit        = 1'b1;
        ctrl.emit_last   = 1'b1;
        ctrl.emit_status = tpse_pkg::ST_OK;
      end
      tpse_pkg::S_ADD_POP:   ctrl.add_pop = 1'b1;
      tpse_pkg::S_ARM_START: ctrl.arm_start = 1'b1;
      tpse_pkg::S_ARM_WALK:  ctrl.arm_step = !stat.arm_stop;
      tpse_pkg::S_ARM_LINK:  ctrl.arm_link = 1'b1;
      tpse_pkg::S_UNL_WALK:  ctrl.unl_step = !stat.unl_stop;
      tpse_pkg::S_UNL_LINK:  ctrl.unl_link = stat.unl_found;
      tpse_pkg::S_DEL_FREE:  ctrl.del_free = 1'b1;
      tpse_pkg::S_EMIT: begin
        ctrl.emit      = 1'b1;
        ctrl.emit_last = 1'b1;
        unique case (stat.op)
          tpse_pkg::OP_ADD: begin
            ctrl.emit_status = stat.free_empty && !busy_add_r ?
                               tpse_pkg::ST_NO_FREE : tpse_pkg::ST_OK;
            ctrl.emit_id_sel = busy_add_r;
          end
          default: begin
            if (stat.id_bad) ctrl.emit_status = tpse_pkg::ST_BAD_ID;
            else if (bad_state_r || unl_seen_r) ctrl.emit_status = tpse_pkg::ST_BAD_STATE;
            else ctrl.emit_status = tpse_pkg::ST_OK;
          end
        endcase
      end
      default: ;
    endcase
    if (state_r == tpse_pkg::S_UNL_WALK) ctrl.unl_start = 1'b0;
    if (state_r == tpse_pkg::S_DECODE && stat.op[1] && !stat.id_bad &&
        stat.id_state == tpse_pkg::TS_RUN) ctrl.unl_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_add_r  <= 1'b0;
      bad_state_r <= 1'b0;
    end else if (state_r == tpse_pkg::S_DECODE) begin
      busy_add_r  <= (stat.op == tpse_pkg::OP_ADD) && !stat.free_empty;
      bad_state_r <= stat.id_state == tpse_pkg::TS_FREE;
    end
  end
endmodule
